// ===== rtl/lorenz_ode_runge_kutta_stepper_assert.svh =====
// Assertion macros for the Lorenz stepper
`ifndef LORENZ_ODE_RUNGE_KUTTA_STEPPER_ASSERT_SVH
`define LORENZ_ODE_RUNGE_KUTTA_STEPPER_ASSERT_SVH

// Property checked on every clock edge outside reset
`define LRK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must be followed by another on the next edge
`define LRK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrk_pkg.sv =====
`default_nettype none
package lrk_pkg;
  localparam logic signed [31:0] QOne  = 32'sd16777216;
  localparam logic signed [31:0] QHalf = 32'sd8388608;
  localparam logic signed [31:0] SMax  = 32'sh7fffffff;
  localparam logic signed [31:0] SMin  = 32'sh80000000;

  localparam logic [2:0] CfgMethod = 3'd0;
  localparam logic [2:0] CfgStep   = 3'd1;
  localparam logic [2:0] CfgSigma  = 3'd2;
  localparam logic [2:0] CfgRho    = 3'd3;
  localparam logic [2:0] CfgBeta   = 3'd4;
  localparam logic [2:0] CfgUnused = 3'd7;   // no register at this index

  localparam logic [2:0] MEuler = 3'd0;
  localparam logic [2:0] MMid   = 3'd1;
  localparam logic [2:0] MRk2   = 3'd2;
  localparam logic [2:0] MRk3   = 3'd3;
  localparam logic [2:0] MRk4   = 3'd4;

  // Microcode operation of the datapath
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_DERIV, OP_SCALE, OP_HALF, OP_RK3S,
    OP_FULLS, OP_EULER, OP_ADDK2, OP_SUM, OP_DIV, OP_FINAL
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sub;    // multiply index / coordinate within op
    logic [1:0] kidx;   // stage number
  } cmd_t;

  function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SMax;
    if (v < -66'sd2147483648) return SMin;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/lrk_if.sv =====
`default_nettype none
interface lrk_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] load_x;
  logic [31:0] load_y;
  logic [31:0] load_z;
  modport source (output valid, action, load_x, load_y, load_z, input ready);
  modport sink (input valid, action, load_x, load_y, load_z, output ready);
endinterface

interface lrk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface lrk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrk_datapath.sv =====
`default_nettype none
module lrk_datapath (
  input  wire logic               clk_i,
  input  wire lrk_pkg::cmd_t      cmd_i,
  input  wire logic               action_i,
  input  wire logic [31:0]        load_x_i,
  input  wire logic [31:0]        load_y_i,
  input  wire logic [31:0]        load_z_i,
  input  wire logic [2:0]         method_i,
  input  wire logic [24:0]        step_i,
  input  wire logic signed [31:0] sigma_i,
  input  wire logic signed [31:0] rho_i,
  input  wire logic signed [31:0] beta_i,
  input  wire logic               rst_ni,
  output logic [31:0]             px_o,
  output logic [31:0]             py_o,
  output logic [31:0]             pz_o
);
  import lrk_pkg::*;

  logic signed [31:0] p_q [3];          // current point
  logic signed [31:0] s_q [3];          // stage point
  logic signed [31:0] k_q [4][3];       // stage increments
  logic signed [31:0] m_q [6];          // products of derivative
  logic signed [31:0] d_q [3];          // derivative
  logic signed [34:0] acc_q;            // weighted sum
  logic signed [31:0] q_q;              // quotient
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] qm;
  logic [1:0] c;
  logic signed [34:0] n;
  logic signed [67:0] rp;
  logic signed [34:0] qt;
  logic signed [35:0] rem;

  assign c = cmd_i.sub[1:0];

  // Operand select for the single shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_DERIV: begin
        case (cmd_i.sub)
          3'd0: begin ma = sigma_i; mb = s_q[1]; end
          3'd1: begin ma = sigma_i; mb = s_q[0]; end
          3'd2: begin ma = rho_i;   mb = s_q[0]; end
          3'd3: begin ma = s_q[0];  mb = s_q[2]; end
          3'd4: begin ma = s_q[0];  mb = s_q[1]; end
          default: begin ma = beta_i; mb = s_q[2]; end
        endcase
      end
      OP_SCALE: begin ma = $signed({7'd0, step_i}); mb = d_q[c]; end
      OP_HALF:  begin ma = QHalf; mb = k_q[cmd_i.kidx][c]; end
      default: ;
    endcase
  end

  always_comb begin
    prod = 64'(ma) * 64'(mb) + 64'sd8388608;
    qm = sat64(66'(prod >>> 24));
  end

  // Division by 6 of acc+3, floor: reciprocal multiply then correction
  always_comb begin
    n = acc_q + 35'sd3;
    rp = 68'(n) * 68'sd715827883;          // ~2^32/6
    qt = 35'(rp >>> 32);
    rem = 36'(n) - 36'(qt) * 36'sd6;
    if (rem < 0) qt = qt - 35'sd1;
    else if (rem >= 36'sd6) qt = qt + 35'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) p_q[i] <= QOne;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (action_i) begin
            p_q[0] <= load_x_i; p_q[1] <= load_y_i; p_q[2] <= load_z_i;
          end
        end
        OP_EULER: p_q[c] <= sat64(66'(p_q[c]) + 66'(k_q[0][c]));
        OP_ADDK2: p_q[c] <= sat64(66'(p_q[c]) + 66'(k_q[1][c]));
        OP_FINAL: p_q[c] <= sat64(66'(p_q[c]) + 66'(q_q));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_INIT: for (int i = 0; i < 3; i++) s_q[i] <= p_q[i];
      OP_DERIV: begin
        m_q[cmd_i.sub] <= qm;
        if (cmd_i.sub == 3'd5) begin
          d_q[0] <= sat64(66'(m_q[0]) - 66'(m_q[1]));
          d_q[1] <= sat64(66'(sat64(66'(m_q[2]) - 66'(m_q[3]))) - 66'(s_q[1]));
          d_q[2] <= sat64(66'(m_q[4]) - 66'(qm));
        end
      end
      OP_SCALE: k_q[cmd_i.kidx][c] <= qm;
      OP_HALF: s_q[c] <= sat64(66'(p_q[c]) + 66'(qm));
      OP_RK3S: s_q[c] <= sat64(66'(sat64(66'(p_q[c]) - 66'(k_q[0][c])))
                               + 66'(sat64(66'(k_q[1][c]) * 66'sd2)));
      OP_FULLS: s_q[c] <= sat64(66'(p_q[c]) + 66'(k_q[2][c]));
      OP_SUM: begin
        if (method_i == MRk3)
          acc_q <= 35'(k_q[0][c]) + 35'(k_q[1][c]) * 35'sd4 + 35'(k_q[2][c]);
        else
          acc_q <= 35'(k_q[0][c]) + 35'(k_q[1][c]) * 35'sd2
                   + 35'(k_q[2][c]) * 35'sd2 + 35'(k_q[3][c]);
      end
      OP_DIV: q_q <= 32'(qt);
      default: ;
    endcase
  end

  assign px_o = p_q[0];
  assign py_o = p_q[1];
  assign pz_o = p_q[2];
endmodule
`default_nettype wire

// ===== rtl/lrk_ctrl.sv =====
`default_nettype none
module lrk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          action_i,
  input  wire logic [2:0]    method_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lrk_pkg::cmd_t      cmd_o
);
  import lrk_pkg::*;
  `include "lorenz_ode_runge_kutta_stepper_assert.svh"

  state_e state_q, state_d;
  cmd_t   pc_q, pc_d;     // current microstep
  logic   last;

  // Microstep sequencer: derive -> scale per stage, then combine
  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    last = 1'b0;
    in_ready_o = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    cmd_o = '{op: OP_NONE, sub: 3'd0, kidx: 2'd0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (action_i || method_i > MRk4) state_d = ST_OUT;
          else begin
            state_d = ST_RUN;
            pc_d = '{op: OP_INIT, sub: 3'd0, kidx: 2'd0};
          end
        end
      end
      ST_RUN: begin
        cmd_o = pc_q;
        case (pc_q.op)
          OP_INIT: pc_d = '{op: OP_DERIV, sub: 3'd0, kidx: pc_q.kidx};
          OP_DERIV:
            if (pc_q.sub == 3'd5) pc_d = '{op: OP_SCALE, sub: 3'd0, kidx: pc_q.kidx};
            else pc_d.sub = pc_q.sub + 3'd1;
          OP_SCALE:
            if (pc_q.sub != 3'd2) pc_d.sub = pc_q.sub + 3'd1;
            else begin
              pc_d.sub = 3'd0;
              case (pc_q.kidx)
                2'd0: pc_d.op = (method_i == MEuler) ? OP_EULER : OP_HALF;
                2'd1: if (method_i == MRk3) pc_d.op = OP_RK3S;
                      else if (method_i == MRk4) pc_d.op = OP_HALF;
                      else pc_d.op = OP_ADDK2;
                2'd2: pc_d.op = (method_i == MRk3) ? OP_SUM : OP_FULLS;
                default: pc_d.op = OP_SUM;
              endcase
            end
          OP_HALF, OP_RK3S, OP_FULLS:
            if (pc_q.sub != 3'd2) pc_d.sub = pc_q.sub + 3'd1;
            else pc_d = '{op: OP_DERIV, sub: 3'd0, kidx: pc_q.kidx + 2'd1};
          OP_SUM: pc_d.op = OP_DIV;
          OP_DIV: pc_d.op = OP_FINAL;
          OP_FINAL:
            if (pc_q.sub != 3'd2) begin
              pc_d.op = OP_SUM; pc_d.sub = pc_q.sub + 3'd1;
            end else last = 1'b1;
          OP_EULER, OP_ADDK2:
            if (pc_q.sub != 3'd2) pc_d.sub = pc_q.sub + 3'd1;
            else last = 1'b1;
          default: last = 1'b1;
        endcase
        // HALF for stage 2 of RK4 reads k2 as kidx
        if (pc_d.op == OP_HALF && pc_q.op == OP_SCALE) pc_d.kidx = pc_q.kidx;
        if (last) state_d = ST_OUT;
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '{op: OP_NONE, sub: 3'd0, kidx: 2'd0};
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
    end
  end

  `LRK_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `LRK_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> !in_ready_o, "accept while busy")
  `LRK_ASSERT(a_run_from_idle, $rose(state_q == ST_RUN) |-> $past(in_valid_i), "no request")
endmodule
`default_nettype wire

// ===== rtl/lorenz_ode_runge_kutta_stepper.sv =====
// Channel | Dir | Payload
// in_ch   | in  | action, load_x, load_y, load_z
// out_ch  | out | out_x, out_y, out_z
// cfg_ch  | in  | index (3b), data (32b)
// A load or an unused method goes straight to the result; Euler, RK2, RK3
// and RK4 run microsteps on one shared 32x32 multiplier doing six products
// per derivative. One request in flight; result holds until taken. Reset:
// point 1.0.
`default_nettype none
module lorenz_ode_runge_kutta_stepper (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lrk_in_if.sink     in_ch,
  lrk_out_if.source  out_ch,
  lrk_cfg_if.sink    cfg_ch
);
  import lrk_pkg::*;

  logic [2:0]         method_q;
  logic [24:0]        step_q;
  logic signed [31:0] sigma_q, rho_q, beta_q;
  cmd_t               cmd;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= MRk3;
      step_q <= 25'd1678;
      sigma_q <= 32'sd167772160;
      rho_q <= 32'sd469762048;
      beta_q <= 32'sd44739243;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CfgMethod: method_q <= cfg_ch.data[2:0];
        CfgStep:   step_q <= cfg_ch.data[24:0];
        CfgSigma:  sigma_q <= cfg_ch.data;
        CfgRho:    rho_q <= cfg_ch.data;
        CfgBeta:   beta_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  lrk_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .action_i(in_ch.action), .method_i(method_q),
    .in_ready_o(in_ch.ready), .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready), .cmd_o(cmd)
  );

  lrk_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .action_i(in_ch.action),
    .load_x_i(in_ch.load_x), .load_y_i(in_ch.load_y), .load_z_i(in_ch.load_z),
    .method_i(method_q), .step_i(step_q), .sigma_i(sigma_q), .rho_i(rho_q),
    .beta_i(beta_q), .px_o(out_ch.out_x), .py_o(out_ch.out_y), .pz_o(out_ch.out_z)
  );
endmodule
`default_nettype wire

// ===== tb/tb_lorenz_ode_runge_kutta_stepper.sv =====
`default_nettype none
module tb_lorenz_ode_runge_kutta_stepper;
  timeunit 1ns;
  timeprecision 1ps;
  import lrk_pkg::*;

  typedef struct packed {
    logic        action;
    logic [31:0] lx;
    logic [31:0] ly;
    logic [31:0] lz;
  } req_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } pt_t;

  localparam longint LIMIT = 64'd2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lrk_in_if  in_ch ();
  lrk_out_if out_ch ();
  lrk_cfg_if cfg_ch ();

  lorenz_ode_runge_kutta_stepper i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and registers
  logic [2:0]   mdl_method = MRk3;
  longint       mdl_h = 1678;
  longint       mdl_sigma = 167772160;
  longint       mdl_rho = 469762048;
  longint       mdl_beta = 44739243;
  longint       cur_x = 16777216, cur_y = 16777216, cur_z = 16777216;

  req_t   pending_reqs[$];
  pt_t    expected_pts[$];
  int     errors = 0;
  bit     calm = 1'b0;
  longint cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q8.24 product, round half up, saturated
  function automatic longint qprod(longint a, longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return sat32(p >>> 24);
  endfunction

  function automatic longint div_six(longint s);
    longint n;
    n = s + 3;
    if (n >= 0) return n / 6;
    return -((-n + 5) / 6);
  endfunction

  // h * f(p) for each coordinate
  function automatic void slope_step(input longint p[3], output longint k[3]);
    longint d[3];
    d[0] = sat32(qprod(mdl_sigma, p[1]) - qprod(mdl_sigma, p[0]));
    d[1] = sat32(sat32(qprod(mdl_rho, p[0]) - qprod(p[0], p[2])) - p[1]);
    d[2] = sat32(qprod(p[0], p[1]) - qprod(mdl_beta, p[2]));
    for (int i = 0; i < 3; i++) k[i] = qprod(mdl_h, d[i]);
  endfunction

  function automatic void midpoint(input longint p[3], input longint k[3],
                                   output longint r[3]);
    for (int i = 0; i < 3; i++) r[i] = sat32(p[i] + qprod(64'sd8388608, k[i]));
  endfunction

  function automatic pt_t predict_point(req_t r);
    longint p[3], k1[3], k2[3], k3[3], k4[3], s[3];
    pt_t o;
    if (r.action) begin
      cur_x = longint'(signed'(r.lx));
      cur_y = longint'(signed'(r.ly));
      cur_z = longint'(signed'(r.lz));
    end else begin
      p[0] = cur_x; p[1] = cur_y; p[2] = cur_z;
      case (mdl_method)
        MEuler: begin
          slope_step(p, k1);
          for (int i = 0; i < 3; i++) p[i] = sat32(p[i] + k1[i]);
        end
        MMid, MRk2: begin
          slope_step(p, k1);
          midpoint(p, k1, s);
          slope_step(s, k2);
          for (int i = 0; i < 3; i++) p[i] = sat32(p[i] + k2[i]);
        end
        MRk3: begin
          slope_step(p, k1);
          midpoint(p, k1, s);
          slope_step(s, k2);
          for (int i = 0; i < 3; i++) s[i] = sat32(sat32(p[i] - k1[i]) + sat32(2 * k2[i]));
          slope_step(s, k3);
          for (int i = 0; i < 3; i++)
            p[i] = sat32(p[i] + div_six(k1[i] + 4 * k2[i] + k3[i]));
        end
        MRk4: begin
          slope_step(p, k1);
          midpoint(p, k1, s);
          slope_step(s, k2);
          midpoint(p, k2, s);
          slope_step(s, k3);
          for (int i = 0; i < 3; i++) s[i] = sat32(p[i] + k3[i]);
          slope_step(s, k4);
          for (int i = 0; i < 3; i++)
            p[i] = sat32(p[i] + div_six(k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]));
        end
        default: ;
      endcase
      cur_x = p[0]; cur_y = p[1]; cur_z = p[2];
    end
    o.px = cur_x[31:0];
    o.py = cur_y[31:0];
    o.pz = cur_z[31:0];
    return o;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= 1'b0;
      in_ch.load_x <= '0;
      in_ch.load_y <= '0;
      in_ch.load_z <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_pts.insert(expected_pts.size(), predict_point(pending_reqs.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
          in_ch.valid <= 1'b1;
          {in_ch.action, in_ch.load_x, in_ch.load_y, in_ch.load_z} <= pending_reqs[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 22);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected point %h %h %h", $time,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z);
          errors++;
        end else begin
          pt_t e;
          e = expected_pts.pop_front();
          if (out_ch.out_x !== e.px) begin
            $display("%0t: out_x expected %h actual %h", $time, e.px, out_ch.out_x);
            errors++;
          end
          if (out_ch.out_y !== e.py) begin
            $display("%0t: out_y expected %h actual %h", $time, e.py, out_ch.out_y);
            errors++;
          end
          if (out_ch.out_z !== e.pz) begin
            $display("%0t: out_z expected %h actual %h", $time, e.pz, out_ch.out_z);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_pts.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // append one request to the driver queue
  task automatic queue_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CfgMethod: mdl_method = val[2:0];
      CfgStep:   mdl_h = longint'(val[24:0]);
      CfgSigma:  mdl_sigma = longint'(signed'(val));
      CfgRho:    mdl_rho = longint'(signed'(val));
      CfgBeta:   mdl_beta = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(50 << 24, 0)) - (25 << 24));
    endcase
  endfunction

  function automatic req_t load_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return '{1'b1, x, y, z};
  endfunction

  function automatic req_t step_req();
    return '{1'b0, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    int m;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, extremes, every method
    queue_req(step_req());
    queue_req(load_req(32'h7fffffff, 32'h80000000, 32'h7fffffff));
    queue_req(step_req());
    queue_req(load_req(32'h80000000, 32'h7fffffff, 32'h80000000));
    queue_req(step_req());
    queue_req(load_req(32'hffffffff, 32'h00000000, 32'h00000001));
    queue_req(step_req());
    wait_drained();
    write_reg(CfgStep, 32'h01000000);
    write_reg(CfgSigma, 32'h7fffffff);
    write_reg(CfgRho, 32'h80000000);
    write_reg(CfgBeta, 32'h7fffffff);
    for (m = 0; m < 8; m++) begin
      write_reg(CfgMethod, m[31:0]);
      queue_req(load_req(32'h40000000, 32'hc0000000, 32'h7fffffff));
      queue_req(step_req());
      wait_drained();
    end
    write_reg(CfgStep, 32'h00000001);
    write_reg(CfgSigma, 32'h80000000);
    write_reg(CfgRho, 32'h7fffffff);
    write_reg(CfgBeta, 32'h80000000);
    write_reg(CfgUnused, 32'hffffffff);
    queue_req(load_req(32'h01000000, 32'h01000000, 32'h01000000));
    queue_req(step_req());
    wait_drained();
    write_reg(CfgStep, 32'h00000000);
    queue_req(step_req());
    wait_drained();

    // random phases: orbits with occasional loads, mostly Lorenz-like settings
    for (int ph = 0; ph < 16; ph++) begin
      calm = (ph == 5);
      write_reg(CfgMethod, 32'($urandom_range(ph % 3 == 0 ? 7 : 4)));
      write_reg(CfgStep, (ph % 4 == 0) ? $urandom : 32'($urandom_range(1 << 20, 1)));
      write_reg(CfgSigma, (ph % 5 == 4) ? $urandom : 32'($urandom_range(20 << 24)));
      write_reg(CfgRho, (ph % 5 == 4) ? $urandom : 32'($urandom_range(40 << 24)));
      write_reg(CfgBeta, (ph % 5 == 4) ? $urandom : 32'($urandom_range(4 << 24)));
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(9) == 0) queue_req(load_req(rand_word(), rand_word(), rand_word()));
        else queue_req(step_req());
      end
      wait_drained();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/lrk_pkg.sv
rtl/lrk_if.sv
rtl/lrk_datapath.sv
rtl/lrk_ctrl.sv
rtl/lorenz_ode_runge_kutta_stepper.sv
tb/tb_lorenz_ode_runge_kutta_stepper.sv
